// ----- sv/csse_pkg.sv -----
// Shared types, widths and codes for the cluster squared-error cost block.
package csse_pkg;

  // Default sizes of the stores.
  localparam int MAX_POINTS_DEF   = 4096;
  localparam int MAX_DIMS_DEF     = 16;
  localparam int MAX_CLUSTERS_DEF = 16;

  // Fixed field widths.
  localparam int FEAT_W   = 32;
  localparam int LABEL_W  = 4;
  localparam int COST_W   = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 5;
  localparam int SUM_W    = 48;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LABEL = 2'd3;

  // Configuration register indexes.
  localparam logic REG_DIM      = 1'b0;
  localparam logic REG_CLUSTERS = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ACC, S_FILL, S_CHK, S_DRD, S_DLD, S_DWT,
    S_LRD, S_LCHK, S_FRD, S_FSUB, S_MUL1, S_MUL2, S_SQ, S_ADD, S_OUT
  } csse_state_t;

  // Divider response.
  typedef struct packed {
    logic                    done;
    logic signed [SUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- sv/csse_if.sv -----
// Valid/ready channel interfaces for feature beats and result beats.
interface csse_in_if;
  import csse_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FEAT_W-1:0] feature_value;
  logic [LABEL_W-1:0]       cluster_label;
  logic                     last;
  modport source(output valid, feature_value, cluster_label, last, input ready);
  modport sink(input valid, feature_value, cluster_label, last, output ready);
endinterface

interface csse_out_if;
  import csse_pkg::*;
  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   total_cost;
  logic [STATUS_W-1:0] status;
  modport source(output valid, total_cost, status, input ready);
  modport sink(input valid, total_cost, status, output ready);
endinterface

// ----- sv/csse_ram.sv -----
// Generic simple dual-port RAM with registered read.
module csse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/csse_div.sv -----
// Bit-serial restoring divider for centroid = sum / count, truncated toward zero.
module csse_div #(
  parameter int CNT_W = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [csse_pkg::SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]                  divisor,
  output csse_pkg::div_rsp_t                rsp
);
  import csse_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  a_r, a_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  // One quotient bit per cycle.
  always_comb begin
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, a_r[SUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      a_nxt    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      neg_nxt  = dividend[SUM_W-1];
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        a_nxt   = {a_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        a_nxt   = {a_r[SUM_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (int'(step_r) == SUM_W - 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r    <= a_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
  end

  // Apply the sign of the sum to the quotient.
  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -signed'(a_r) : signed'(a_r);

endmodule

// ----- sv/cluster_sse_cost.sv -----
// A feature beat is taken in IDLE and added into its cluster sum in ACC; the last beat
// starts a final pass, run by the shared divider and multiplier. No beat is taken
// while ACC is busy with the one before; the result then waits in OUT.
// Reset (synchronous, active low) clears counters and status and starts a clearing
// sweep over all MAX_CLUSTERS*MAX_DIMS entries of the sum memory; the same sweep follows
// every result. No beat is accepted during a sweep. Config resets to 1 and 1.
module cluster_sse_cost #(
  parameter int MAX_POINTS   = csse_pkg::MAX_POINTS_DEF,
  parameter int MAX_DIMS     = csse_pkg::MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = csse_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  csse_in_if.sink                    in_ch,
  csse_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [csse_pkg::CFG_W-1:0] cfg_wdata
);
  import csse_pkg::*;

  localparam int MP     = MAX_POINTS;
  localparam int MD     = MAX_DIMS;
  localparam int MC     = MAX_CLUSTERS;
  localparam int SD     = MC * MD;
  localparam int P_W    = (MP > 1) ? $clog2(MP) : 1;
  localparam int CNT_W  = $clog2(MP + 1);
  localparam int PC_W   = $clog2(MP + 2);
  localparam int D_W    = (MD > 1) ? $clog2(MD) : 1;
  localparam int FC_W   = $clog2(MD + 1);
  localparam int C_W    = (MC > 1) ? $clog2(MC) : 1;
  localparam int KC_W   = $clog2(MC + 1);
  localparam int FA_W   = (MP * MD > 1) ? $clog2(MP * MD) : 1;
  localparam int SA_W   = (SD > 1) ? $clog2(SD) : 1;
  localparam int DIFF_W = SUM_W + 1;

  csse_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  dim_r, clus_r;
  logic [FC_W-1:0]   d_eff;
  logic [KC_W-1:0]   kc_eff;

  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [LABEL_W-1:0] cur_label_r, cur_label_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [COST_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]  counts_r [MC];
  logic [CNT_W-1:0]  counts_nxt [MC];

  logic signed [FEAT_W-1:0] x_r, x_nxt;
  logic              add_r, add_nxt;
  logic              last_r, last_nxt;
  logic              valid_r, valid_nxt;
  logic [SA_W-1:0]   sa_r, sa_nxt;
  logic [P_W-1:0]    pfill_r, pfill_nxt;

  logic [C_W-1:0]    c_r, c_nxt;
  logic [D_W-1:0]    f_r, f_nxt;
  logic [CNT_W-1:0]  pp_r, pp_nxt;
  logic [LABEL_W-1:0] l_r, l_nxt;
  logic [SUM_W-1:0]  m_r, m_nxt;
  logic [COST_W-1:0] p1_r, p1_nxt;
  logic [30:0]       p2_r, p2_nxt;
  logic [COST_W-1:0] sq_r, sq_nxt;
  logic [SA_W-1:0]   ca_r, ca_nxt;

  // Memory ports.
  logic              fs_we;
  logic [FA_W-1:0]   fs_waddr, fs_raddr;
  logic [FEAT_W-1:0] fs_wdata, fs_rdata;
  logic              ls_we;
  logic [P_W-1:0]    ls_waddr, ls_raddr;
  logic [LABEL_W-1:0] ls_wdata, ls_rdata;
  logic              sm_we;
  logic [SA_W-1:0]   sm_waddr, sm_raddr;
  logic [SUM_W-1:0]  sm_wdata, sm_rdata;

  // Shared divider and multiplier.
  logic              div_start;
  logic signed [SUM_W-1:0] div_dividend;
  logic [CNT_W-1:0]  div_divisor;
  div_rsp_t          div_rsp;
  logic [31:0]       mul_b;
  logic [63:0]       prod;

  // Item decode on the incoming beat.
  logic [FC_W-1:0]   fc0;
  logic              first;
  logic              lab_bad;
  logic [PC_W-1:0]   pc_new;
  logic              valid_new;
  logic [LABEL_W-1:0] lbl;
  logic [P_W-1:0]    pidx;
  logic              in_acc, out_acc;
  logic [CNT_W-1:0]  n_pts;
  logic              f_end, c_end;

  csse_ram #(.WIDTH(FEAT_W), .DEPTH(MP * MD)) u_feat (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata)
  );

  csse_ram #(.WIDTH(LABEL_W), .DEPTH(MP)) u_label (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(ls_raddr), .rdata(ls_rdata)
  );

  csse_ram #(.WIDTH(SUM_W), .DEPTH(SD)) u_sum (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata)
  );

  csse_div #(.CNT_W(CNT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .rsp(div_rsp)
  );

  // Effective register values: zero acts as one, large values clip to the maximum.
  always_comb begin
    if (dim_r == '0) begin
      d_eff = FC_W'(1);
    end else if (int'(dim_r) > MD) begin
      d_eff = FC_W'(MD);
    end else begin
      d_eff = FC_W'(dim_r);
    end
    if (clus_r == '0) begin
      kc_eff = KC_W'(1);
    end else if (int'(clus_r) > MC) begin
      kc_eff = KC_W'(MC);
    end else begin
      kc_eff = KC_W'(clus_r);
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = (state_r == S_OUT);
  assign out_acc           = out_ch.valid && out_ch.ready;
  assign out_ch.total_cost = (err_r != ST_OK) ? '0 : acc_r;
  assign out_ch.status     = err_r;

  // Decode of the beat at the input.
  always_comb begin
    fc0       = (fc_r >= d_eff) ? '0 : fc_r;
    first     = (fc0 == '0);
    lab_bad   = int'(in_ch.cluster_label) >= int'(kc_eff);
    if (first) begin
      pc_new = (int'(pc_r) >= MP) ? PC_W'(MP + 1) : pc_r + 1'b1;
    end else begin
      pc_new = pc_r;
    end
    valid_new = (pc_new != '0) && (int'(pc_new) <= MP);
    lbl       = first ? in_ch.cluster_label : cur_label_r;
    pidx      = P_W'(int'(pc_new) - 1);
    n_pts     = (int'(pc_r) > MP) ? CNT_W'(MP) : CNT_W'(pc_r);
    f_end     = int'(f_r) == int'(d_eff) - 1;
    c_end     = int'(c_r) == int'(kc_eff) - 1;
  end

  // One shared multiplier: low-half square, then low-half times high-half.
  assign mul_b = (state_r == S_MUL2) ? {{(64 - SUM_W){1'b0}}, m_r[SUM_W-1:32]} : m_r[31:0];
  assign prod  = {32'b0, m_r[31:0]} * {32'b0, mul_b};

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (int'(ca_r) == SD - 1) state_nxt = S_IDLE;
      S_IDLE: if (in_ch.valid) state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_FILL : S_IDLE;
      S_FILL: if (!(valid_r && fc_r < d_eff)) state_nxt = S_CHK;
      S_CHK: begin
        if (err_r != ST_OK || counts_r[c_r] == '0) begin
          state_nxt = S_OUT;
        end else if (c_end) begin
          state_nxt = S_DRD;
        end
      end
      S_DRD:  state_nxt = S_DLD;
      S_DLD:  state_nxt = S_DWT;
      S_DWT: begin
        if (div_rsp.done) state_nxt = (f_end && c_end) ? S_LRD : S_DRD;
      end
      S_LRD:  state_nxt = (pp_r == n_pts) ? S_OUT : S_LCHK;
      S_LCHK: state_nxt = (int'(ls_rdata) >= int'(kc_eff)) ? S_OUT : S_FRD;
      S_FRD:  state_nxt = S_FSUB;
      S_FSUB: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_ADD;
      S_ADD:  state_nxt = f_end ? S_LRD : S_FRD;
      S_OUT:  if (out_ch.ready) state_nxt = S_CLR;
      default: state_nxt = S_CLR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    logic [DIFF_W-1:0] diff;
    logic [COST_W:0]   sum65;
    diff          = '0;
    sum65         = '0;
    fc_nxt        = fc_r;
    pc_nxt        = pc_r;
    cur_label_nxt = cur_label_r;
    err_nxt       = err_r;
    acc_nxt       = acc_r;
    counts_nxt    = counts_r;
    x_nxt         = x_r;
    add_nxt       = add_r;
    last_nxt      = last_r;
    valid_nxt     = valid_r;
    sa_nxt        = sa_r;
    pfill_nxt     = pfill_r;
    c_nxt         = c_r;
    f_nxt         = f_r;
    pp_nxt        = pp_r;
    l_nxt         = l_r;
    m_nxt         = m_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    sq_nxt        = sq_r;
    ca_nxt        = ca_r;
    fs_we         = 1'b0;
    fs_waddr      = '0;
    fs_wdata      = '0;
    fs_raddr      = '0;
    ls_we         = 1'b0;
    ls_waddr      = '0;
    ls_wdata      = '0;
    ls_raddr      = '0;
    sm_we         = 1'b0;
    sm_waddr      = '0;
    sm_wdata      = '0;
    sm_raddr      = '0;
    div_start     = 1'b0;
    div_dividend  = sm_rdata;
    div_divisor   = counts_r[c_r];
    unique case (state_r)
      // Zero the sum memory, one entry a cycle.
      S_CLR: begin
        sm_we    = 1'b1;
        sm_waddr = ca_r;
        ca_nxt   = ca_r + 1'b1;
      end
      // Take a feature beat: store it and fetch its running sum.
      S_IDLE: begin
        if (in_acc) begin
          if (first) begin
            if (int'(pc_r) >= MP) begin
              if (err_r == ST_OK) err_nxt = ST_TOO_MANY;
            end else begin
              ls_we         = 1'b1;
              ls_waddr      = P_W'(pc_r);
              ls_wdata      = in_ch.cluster_label;
              cur_label_nxt = in_ch.cluster_label;
              if (lab_bad) begin
                if (err_r == ST_OK) err_nxt = ST_BAD_LABEL;
              end else begin
                counts_nxt[C_W'(in_ch.cluster_label)] =
                  counts_r[C_W'(in_ch.cluster_label)] + 1'b1;
              end
            end
          end
          pc_nxt    = pc_new;
          fs_we     = valid_new;
          fs_waddr  = FA_W'(int'(pidx) * MD + int'(fc0));
          fs_wdata  = in_ch.feature_value;
          sm_raddr  = SA_W'(int'(lbl) * MD + int'(fc0));
          sa_nxt    = SA_W'(int'(lbl) * MD + int'(fc0));
          add_nxt   = valid_new && (int'(lbl) < int'(kc_eff));
          x_nxt     = in_ch.feature_value;
          last_nxt  = in_ch.last;
          valid_nxt = valid_new;
          pfill_nxt = pidx;
          if (!in_ch.last && (fc0 + 1'b1 >= d_eff)) begin
            fc_nxt = '0;
          end else begin
            fc_nxt = fc0 + 1'b1;
          end
        end
      end
      // Add the feature into its cluster sum.
      S_ACC: begin
        sm_we    = add_r;
        sm_waddr = sa_r;
        sm_wdata = sm_rdata + {{(SUM_W - FEAT_W){x_r[FEAT_W-1]}}, x_r};
        c_nxt    = '0;
      end
      // Missing features of a short final point are stored as zero.
      S_FILL: begin
        if (valid_r && fc_r < d_eff) begin
          fs_we    = 1'b1;
          fs_waddr = FA_W'(int'(pfill_r) * MD + int'(fc_r));
          fs_wdata = '0;
          fc_nxt   = fc_r + 1'b1;
        end
      end
      // Scan the member counts for an empty cluster.
      S_CHK: begin
        if (err_r != ST_OK) begin
          err_nxt = err_r;
        end else if (counts_r[c_r] == '0) begin
          err_nxt = ST_EMPTY;
        end else if (c_end) begin
          c_nxt = '0;
          f_nxt = '0;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_DRD: begin
        sm_raddr = SA_W'(int'(c_r) * MD + int'(f_r));
      end
      S_DLD: begin
        div_start = 1'b1;
      end
      // Centroid overwrites its sum.
      S_DWT: begin
        if (div_rsp.done) begin
          sm_we    = 1'b1;
          sm_waddr = SA_W'(int'(c_r) * MD + int'(f_r));
          sm_wdata = div_rsp.quot;
          if (f_end) begin
            f_nxt = '0;
            if (c_end) begin
              pp_nxt = '0;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end else begin
            f_nxt = f_r + 1'b1;
          end
        end
      end
      S_LRD: begin
        ls_raddr = P_W'(pp_r);
      end
      S_LCHK: begin
        if (int'(ls_rdata) >= int'(kc_eff)) begin
          if (err_r == ST_OK) err_nxt = ST_BAD_LABEL;
        end else begin
          l_nxt = ls_rdata;
          f_nxt = '0;
        end
      end
      S_FRD: begin
        fs_raddr = FA_W'(int'(pp_r) * MD + int'(f_r));
        sm_raddr = SA_W'(int'(l_r) * MD + int'(f_r));
      end
      // Magnitude of feature minus centroid.
      S_FSUB: begin
        diff  = {{(DIFF_W - FEAT_W){fs_rdata[FEAT_W-1]}}, fs_rdata}
              - {sm_rdata[SUM_W-1], sm_rdata};
        m_nxt = diff[DIFF_W-1] ? SUM_W'(-diff) : diff[SUM_W-1:0];
      end
      S_MUL1: begin
        p1_nxt = prod;
      end
      S_MUL2: begin
        p2_nxt = prod[30:0];
      end
      // Square modulo 2^64: lo*lo plus 2*lo*hi shifted by 32.
      S_SQ: begin
        sq_nxt = p1_r + {p2_r, 33'b0};
      end
      // Saturating accumulate.
      S_ADD: begin
        sum65   = {1'b0, acc_r} + {1'b0, sq_r};
        acc_nxt = sum65[COST_W] ? '1 : sum65[COST_W-1:0];
        if (f_end) begin
          pp_nxt = pp_r + 1'b1;
        end else begin
          f_nxt = f_r + 1'b1;
        end
      end
      // Result beat; the set state clears once it is taken.
      S_OUT: begin
        if (out_acc) begin
          pc_nxt  = '0;
          fc_nxt  = '0;
          err_nxt = ST_OK;
          acc_nxt = '0;
          ca_nxt  = '0;
          for (int i = 0; i < MC; i++) begin
            counts_nxt[i] = '0;
          end
        end
      end
      default: begin
        ca_nxt = '0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= CFG_W'(1);
      clus_r <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIM:      dim_r  <= cfg_wdata;
        REG_CLUSTERS: clus_r <= cfg_wdata;
        default:      dim_r  <= dim_r;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ca_r    <= '0;
      fc_r    <= '0;
      pc_r    <= '0;
      err_r   <= ST_OK;
      acc_r   <= '0;
      for (int i = 0; i < MC; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ca_r     <= ca_nxt;
      fc_r     <= fc_nxt;
      pc_r     <= pc_nxt;
      err_r    <= err_nxt;
      acc_r    <= acc_nxt;
      counts_r <= counts_nxt;
    end
    cur_label_r <= cur_label_nxt;
    x_r         <= x_nxt;
    add_r       <= add_nxt;
    last_r      <= last_nxt;
    valid_r     <= valid_nxt;
    sa_r        <= sa_nxt;
    pfill_r     <= pfill_nxt;
    c_r         <= c_nxt;
    f_r         <= f_nxt;
    pp_r        <= pp_nxt;
    l_r         <= l_nxt;
    m_r         <= m_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    sq_r        <= sq_nxt;
  end

`ifndef NO_ASSERTIONS
  // Input is never taken while a result beat is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("input ready during result");

  // A raised status holds until the result beat is taken.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK && !out_acc) |=> (err_r == $past(err_r)))
    else $error("status changed inside a set");

  // The point counter never runs past its overflow mark.
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(pc_r) <= MP + 1) else $error("point counter out of range");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DWT)) else $error("unexpected divider done");
`endif

endmodule
